FILE: rtl/core/lfia_pkg.sv
// ----------------------------------------------------------------------------
// lfia_pkg
// Shared sizes, codes and bit helpers of the lowest free id allocator.
// ----------------------------------------------------------------------------
package lfia_pkg;

    localparam int ID_BITS   = 16;
    localparam int ID_SPAN   = 1 << ID_BITS;
    localparam int W_AW      = (ID_BITS > 6) ? ID_BITS - 6 : 1;
    localparam int MAP_WORDS = (ID_BITS > 6) ? (1 << (ID_BITS - 6)) : 1;
    localparam int GROUP_AW  = (W_AW > 6) ? W_AW - 6 : 1;
    localparam int GROUPS    = (W_AW > 6) ? (1 << (W_AW - 6)) : 1;
    localparam int ADDR_BITS = 48;

    typedef logic [ID_BITS-1:0]  t_id;
    typedef logic [W_AW-1:0]     t_word;
    typedef logic [GROUP_AW-1:0] t_group;
    typedef logic [63:0]         t_bits;

    localparam t_id   MAX_ID     = '1;
    localparam t_word CLR_LAST   = t_word'(MAP_WORDS - 1);
    localparam t_bits SPAN_MASK  = (ID_SPAN >= 64) ? '1 : ((64'd1 << ID_SPAN) - 64'd1);
    localparam t_bits GROUP_MASK = (MAP_WORDS >= 64) ? '1 : ((64'd1 << MAP_WORDS) - 64'd1);
    localparam logic [ADDR_BITS-1:0] LOCAL_BIT = 48'h02_0000_000000;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SUM,
        S_A_MAP,
        S_R_MAP,
        S_RESULT
    } t_state;

    // Bits of a map word that stand for real ids; id zero is never handed out
    function automatic t_bits word_mask(input t_word w);
        t_bits m;
        m = SPAN_MASK;
        if (w == '0) begin
            m[0] = 1'b0;
        end
        return m;
    endfunction

    function automatic logic [5:0] lowest_one(input t_bits v);
        logic [5:0] r;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) begin
                r = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/lfia_ram.sv
// ----------------------------------------------------------------------------
// lfia_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lfia_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lowest_free_id_allocator.sv
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Hands out the lowest free interface id as a locally administered MAC
// address and takes ids back on release.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser carries the operation (0 allocate, 1 release) and
//   tdata the 48-bit address whose low id bits name the id to release.
//   Output stream: one item per allocate, none per release. tdata holds the
//   address (id in the low bits, 0x02 in the top byte), tuser the exhausted
//   flag; an exhausted answer carries an all-zero address.
//   An allocate runs from acceptance to a valid result through these steps:
//   a lookup in the group-full flags, a read of the word-full summary RAM,
//   a read-modify-write of the used-map RAM, then the output register.
//   An exhausted allocate goes straight to the output register. A release
//   is one read-modify-write of both RAMs. One item is in work at a time.
//   After reset the block sweeps both RAMs clear, one word a cycle, over
//   all MAP_WORDS (1024) map words with tready low.
//   When the receiver stalls, a finished result holds in the output register
//   and the next item is still taken; a second result waits until the first
//   has gone.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [lfia_pkg::ADDR_BITS-1:0] i_s_axis_tdata,  // [47:0] release_address
    input  logic                           i_s_axis_tuser,  // [0] operation
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [lfia_pkg::ADDR_BITS-1:0] o_m_axis_tdata,  // [47:0] assigned_address
    output logic                           o_m_axis_tuser   // [0] exhausted
);
    import lfia_pkg::*;

    t_state r_state, n_state;
    t_word  r_clr, n_clr;
    t_id    r_count, n_count;
    logic [GROUPS-1:0] r_group_full, n_group_full;
    t_id    r_id, n_id;
    t_word  r_word, n_word;
    t_group r_group, n_group;
    t_bits  r_sum, n_sum;
    logic [ADDR_BITS-1:0] r_res_addr, n_res_addr;
    logic   r_res_exh, n_res_exh;
    logic   r_out_valid, n_out_valid;
    logic [ADDR_BITS-1:0] r_out_addr, n_out_addr;
    logic   r_out_exh, n_out_exh;

    logic   map_we, sum_we;
    t_word  map_waddr, map_raddr;
    t_bits  map_wdata, map_rdata;
    t_group sum_waddr, sum_raddr;
    t_bits  sum_wdata, sum_rdata;

    logic   s_acc;
    t_id    in_id;
    t_word  in_word;
    t_group in_group;
    t_group free_group;
    logic [5:0] a_sub;
    t_word  a_word;
    t_bits  a_mask, a_new, a_sum_new;
    logic [5:0] a_bit;
    t_bits  r_bitmask, sub_bitmask;
    logic   r_hit;

    function automatic t_group lowest_zero(input logic [GROUPS-1:0] v);
        t_group r;
        r = '0;
        for (int i = GROUPS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                r = t_group'(i);
            end
        end
        return r;
    endfunction

    assign s_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign in_id      = t_id'(i_s_axis_tdata);
    assign in_word    = t_word'(in_id >> 6);
    assign in_group   = (GROUPS > 1) ? t_group'(in_word >> 6) : '0;
    assign free_group = lowest_zero(r_group_full);

    // Allocate path
    assign a_sub      = lowest_one(~sum_rdata & GROUP_MASK);
    assign a_word     = t_word'({r_group, a_sub});
    assign a_mask     = word_mask(r_word);
    assign a_bit      = lowest_one(~map_rdata & a_mask);
    assign a_new      = map_rdata | (64'd1 << a_bit);
    assign a_sum_new  = r_sum | sub_bitmask;

    // Release path; sub_bitmask also serves the allocate path
    assign r_bitmask   = 64'd1 << 6'(r_id);
    assign sub_bitmask = 64'd1 << 6'(r_word);
    assign r_hit       = (r_id != '0) && ((map_rdata & r_bitmask) != '0);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = r_out_exh;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    if (t_op'(i_s_axis_tuser) == OP_RELEASE) begin
                        n_state = S_R_MAP;
                    end else if (r_count == MAX_ID) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_A_SUM;
                    end
                end
            end
            S_A_SUM:  n_state = S_A_MAP;
            S_A_MAP:  n_state = S_RESULT;
            S_R_MAP:  n_state = S_IDLE;
            S_RESULT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_clr        = r_clr;
        n_count      = r_count;
        n_group_full = r_group_full;
        n_id         = r_id;
        n_word       = r_word;
        n_group      = r_group;
        n_sum        = r_sum;
        n_res_addr   = r_res_addr;
        n_res_exh    = r_res_exh;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_addr   = r_out_addr;
        n_out_exh    = r_out_exh;
        map_we       = 1'b0;
        map_waddr    = r_word;
        map_wdata    = '0;
        map_raddr    = in_word;
        sum_we       = 1'b0;
        sum_waddr    = r_group;
        sum_wdata    = '0;
        sum_raddr    = in_group;
        case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr;
                sum_we    = 1'b1;
                sum_waddr = (GROUPS > 1) ? t_group'(r_clr) : '0;
                n_clr     = r_clr + t_word'(1);
            end
            S_IDLE: begin
                if (s_acc) begin
                    n_id = in_id;
                    if (t_op'(i_s_axis_tuser) == OP_RELEASE) begin
                        n_word  = in_word;
                        n_group = in_group;
                    end else begin
                        n_group    = free_group;
                        sum_raddr  = free_group;
                        n_res_addr = '0;
                        n_res_exh  = 1'b1;
                    end
                end
            end
            S_A_SUM: begin
                n_word    = a_word;
                n_sum     = sum_rdata;
                map_raddr = a_word;
            end
            S_A_MAP: begin
                map_we     = 1'b1;
                map_wdata  = a_new;
                n_count    = r_count + t_id'(1);
                n_res_addr = (ADDR_BITS'(r_word) << 6) | ADDR_BITS'(a_bit) | LOCAL_BIT;
                n_res_exh  = 1'b0;
                // Word now full: mark it in the summary, and the group if that fills too
                if ((a_new & a_mask) == a_mask) begin
                    sum_we    = 1'b1;
                    sum_wdata = a_sum_new;
                    if ((a_sum_new & GROUP_MASK) == GROUP_MASK) begin
                        n_group_full[r_group] = 1'b1;
                    end
                end
            end
            S_R_MAP: begin
                if (r_hit) begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata & ~r_bitmask;
                    sum_we    = 1'b1;
                    sum_wdata = sum_rdata & ~sub_bitmask;
                    n_count   = r_count - t_id'(1);
                    n_group_full[r_group] = 1'b0;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_exh   = r_res_exh;
                end
            end
            default: begin
                n_clr = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_count      <= '0;
            r_group_full <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_count      <= n_count;
            r_group_full <= n_group_full;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id       <= n_id;
        r_word     <= n_word;
        r_group    <= n_group;
        r_sum      <= n_sum;
        r_res_addr <= n_res_addr;
        r_res_exh  <= n_res_exh;
        r_out_addr <= n_out_addr;
        r_out_exh  <= n_out_exh;
    end

    lfia_ram #(
        .WIDTH  (64),
        .DEPTH  (MAP_WORDS),
        .ADDR_W (W_AW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    lfia_ram #(
        .WIDTH  (64),
        .DEPTH  (GROUPS),
        .ADDR_W (GROUP_AW)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

endmodule

FILE: rtl/core/lfia_chk.sv
// ----------------------------------------------------------------------------
// lfia_chk
// Port-level checks of the lowest free id allocator, bound to the top level.
// ----------------------------------------------------------------------------
module lfia_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    input  logic                           o_s_axis_tready,
    input  logic [lfia_pkg::ADDR_BITS-1:0] i_s_axis_tdata,
    input  logic                           i_s_axis_tuser,
    input  logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [lfia_pkg::ADDR_BITS-1:0] o_m_axis_tdata,
    input  logic                           o_m_axis_tuser
);
    import lfia_pkg::*;

    localparam logic [ADDR_BITS-1:0] ID_FIELD = ADDR_BITS'(MAX_ID);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_exh_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("exhausted result with nonzero address");

    a_addr_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            ((o_m_axis_tdata & ~(LOCAL_BIT | ID_FIELD)) == '0) &&
            ((o_m_axis_tdata & LOCAL_BIT) != '0) &&
            ((o_m_axis_tdata & ID_FIELD) != '0))
        else $error("allocated address malformed");

    // Out of reset, no item is taken and no result shown as the map sweep begins
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("ready during clearing sweep");

endmodule

bind lowest_free_id_allocator lfia_chk u_lfia_chk (.*);

FILE: test/lowest_free_id_allocator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_checker
// Watches both streams of the allocator, keeps its own copy of the id map,
// predicts each allocate answer and compares it with what comes out.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [lfia_pkg::ADDR_BITS-1:0] i_s_tdata,  // [47:0] release_address
    input  logic                           i_s_tuser,  // [0] operation
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [lfia_pkg::ADDR_BITS-1:0] i_m_tdata,  // [47:0] assigned_address
    input  logic                           i_m_tuser,  // [0] exhausted
    output int unsigned                    o_faults,
    output int unsigned                    o_outstanding,
    output int unsigned                    o_answers,
    output int unsigned                    o_exhausted,
    output int unsigned                    o_releases
);

    import lfia_pkg::*;

    typedef struct {
        logic [ADDR_BITS-1:0] addr;
        logic                 exhausted;
    } t_answer;

    t_bits       id_map [MAP_WORDS];
    bit          word_full [MAP_WORDS];
    int unsigned ids_used;
    int          first_open;   // every word below this one is full

    t_answer     answer_q [$];
    int unsigned fault_count;
    int unsigned answer_count;
    int unsigned exhaust_count;
    int unsigned release_count;

    function automatic t_bits live_bits(input int w);
        return SPAN_MASK & ~((w == 0) ? t_bits'(1) : t_bits'(0));
    endfunction

    function automatic void clear_map();
        for (int w = 0; w < MAP_WORDS; w++) begin
            id_map[w]    = '0;
            word_full[w] = 1'b0;
        end
        ids_used   = 0;
        first_open = 0;
    endfunction

    function automatic t_answer take_lowest();
        t_answer a;
        t_bits   free_bits;
        int      w;
        int      b;
        a.addr      = '0;
        a.exhausted = 1'b1;
        if (ids_used >= MAX_ID) begin
            return a;
        end
        w = first_open;
        while (w < MAP_WORDS && word_full[w]) begin
            w++;
        end
        if (w >= MAP_WORDS) begin
            return a;
        end
        free_bits = ~id_map[w] & live_bits(w);
        b = 0;
        while (b < 63 && !free_bits[b]) begin
            b++;
        end
        id_map[w][b] = 1'b1;
        ids_used++;
        word_full[w] = (id_map[w] & live_bits(w)) == live_bits(w);
        first_open   = w;
        a.addr       = ADDR_BITS'((w << 6) | b) | LOCAL_BIT;
        a.exhausted  = 1'b0;
        return a;
    endfunction

    function automatic void free_id(input t_id id);
        int w;
        int b;
        w = int'(id) >> 6;
        b = int'(id) & 63;
        // id zero and ids not in use are left alone
        if (id != '0 && w < MAP_WORDS && id_map[w][b]) begin
            id_map[w][b] = 1'b0;
            ids_used--;
            word_full[w] = 1'b0;
            if (w < first_open) begin
                first_open = w;
            end
        end
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
    endfunction

    task automatic check_answer();
        t_answer exp;
        answer_count++;
        if (i_m_tuser === 1'b1) begin
            exhaust_count++;
        end
        if (answer_q.size() == 0) begin
            note_fault($sformatf("answer %h/%b with no allocate outstanding",
                                 i_m_tdata, i_m_tuser));
        end else begin
            exp = answer_q.pop_front();
            if (i_m_tdata !== exp.addr) begin
                note_fault($sformatf("assigned_address exp %h got %h",
                                     exp.addr, i_m_tdata));
            end
            if (i_m_tuser !== exp.exhausted) begin
                note_fault($sformatf("exhausted exp %b got %b (address %h)",
                                     exp.exhausted, i_m_tuser, exp.addr));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_map();
            answer_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                if (t_op'(i_s_tuser) == OP_ALLOC) begin
                    answer_q.push_back(take_lowest());
                end else begin
                    free_id(i_s_tdata[ID_BITS-1:0]);
                    release_count++;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                check_answer();
            end
        end
        o_faults      <= fault_count;
        o_outstanding <= answer_q.size();
        o_answers     <= answer_count;
        o_exhausted   <= exhaust_count;
        o_releases    <= release_count;
    end

endmodule

FILE: test/lowest_free_id_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lowest_free_id_allocator_test
// Drives allocate and release items into the allocator with random gaps and
// output stalls, covers ignored releases and reuse of freed ids, and reports
// the verdict from the checker's fault and outstanding counts.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator_test;

    import lfia_pkg::*;

    localparam int unsigned STALL_LIMIT  = 5000;   // outlasts the clear sweep of 1024 map words
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 1370;
    localparam int unsigned TAIL_ITEMS   = 150;
    localparam int unsigned DRAIN_CYCLES = 16;

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic [ADDR_BITS-1:0] s_data  = '0;
    logic                 s_user  = 1'b0;
    logic                 m_ready = 1'b0;

    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [ADDR_BITS-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    int unsigned faults;
    int unsigned outstanding;
    int unsigned answers;
    int unsigned exhausted_seen;
    int unsigned releases_seen;

    logic        quick       = 1'b0;
    logic        hold_wanted = 1'b0;
    logic        hold_done   = 1'b0;
    int unsigned allocs_sent = 0;
    int unsigned quiet_cycles = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lowest_free_id_allocator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),            // [47:0] release_address
        .i_s_axis_tuser  (s_user),            // [0] operation
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // [47:0] assigned_address
        .o_m_axis_tuser  (o_m_axis_tuser)     // [0] exhausted
    );

    lowest_free_id_allocator_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (s_data),
        .i_s_tuser     (s_user),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (o_m_axis_tdata),
        .i_m_tuser     (o_m_axis_tuser),
        .o_faults      (faults),
        .o_outstanding (outstanding),
        .o_answers     (answers),
        .o_exhausted   (exhausted_seen),
        .o_releases    (releases_seen)
    );

    // Hold valid across back-to-back items; lower it only when a gap is drawn
    task automatic send_item(input t_op op, input logic [ADDR_BITS-1:0] addr);
        int unsigned gap;
        gap = quick ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= addr;
        s_user  <= op;
        @(posedge clk);
        while (!o_s_axis_tready) begin
            @(posedge clk);
        end
        if (op == OP_ALLOC) begin
            allocs_sent++;
        end
    endtask

    task automatic alloc_item();
        send_item(OP_ALLOC, {$urandom(), 16'($urandom())});
    endtask

    // Random bits above the id must make no difference
    task automatic release_id(input t_id id);
        send_item(OP_RELEASE, {$urandom(), id});
    endtask

    // Receiver: random pause before each item, one long hold on request
    initial begin : receiver
        int unsigned pause;
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if (hold_wanted && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done <= 1'b1;
            end else begin
                pause = quick ? 0 : $urandom_range(0, 4);
                if (pause > 0) begin
                    m_ready <= 1'b0;
                    repeat (pause) @(posedge clk);
                end
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!o_m_axis_tvalid) begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int unsigned sel;
        int unsigned ceiling;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ids 1..6, then the ignored releases and reuse of low ids
        send_item(OP_ALLOC, '0);
        send_item(OP_ALLOC, '1);
        repeat (4) alloc_item();
        send_item(OP_RELEASE, '0);                    // id zero
        send_item(OP_RELEASE, 48'hFFFF_FFFF_0000);    // id zero, high bits set
        send_item(OP_RELEASE, 48'h0000_0000_0100);    // id never handed out
        send_item(OP_RELEASE, '1);                    // top id, free
        send_item(OP_RELEASE, 48'hA5A5_5A5A_0003);    // id 3 behind junk
        release_id(16'd3);                            // already free
        send_item(OP_RELEASE, 48'h0200_0000_0001);    // the address as handed out
        repeat (3) alloc_item();
        release_id(16'd5);
        release_id(16'd2);
        repeat (3) alloc_item();

        // Random mix, mostly allocates and releases of ids likely in use
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            quick <= ((i / 64) % 3) == 2;
            if (i == 400) begin
                hold_wanted <= 1'b1;
            end
            ceiling = (allocs_sent + 8 > MAX_ID) ? MAX_ID : allocs_sent + 8;
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                alloc_item();
            end else if (sel < 90) begin
                release_id(t_id'($urandom_range(1, ceiling)));
            end else begin
                send_item(OP_RELEASE, {$urandom(), 16'($urandom())});
            end
        end

        // Free a few ids and take them back
        release_id(MAX_ID);
        release_id(16'h8000);
        send_item(OP_RELEASE, 48'h0200_0000_0001);
        repeat (4) alloc_item();
        send_item(OP_RELEASE, 48'hFFFF_FFFF_0000);
        alloc_item();

        // Churn over the whole id range: any id may be named
        for (int unsigned i = 0; i < TAIL_ITEMS; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                alloc_item();
            end else begin
                release_id(t_id'($urandom_range(0, MAX_ID)));
            end
        end
        s_valid <= 1'b0;

        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d allocate answers checked, %0d of them exhausted, %0d releases",
                 answers, exhausted_seen, releases_seen);
        $display("run: ignored releases, id reuse, random gaps, one output stall of %0d cycles",
                 HOLD_CYCLES);
        if (faults == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches", faults);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
